FILE: rtl/core/rcs_pkg.sv
// Package for the recurrent cell step block: sizes, function codes and a divide helper.
// Depends on nothing.
package rcs_pkg;
   localparam int HIDDEN_DEF = 32;
   localparam int SYMBOLS_DEF = 256;
   localparam logic [2:0] FUNC_LOAD_IN = 3'd0;
   localparam logic [2:0] FUNC_LOAD_REC = 3'd1;
   localparam logic [2:0] FUNC_LOAD_BIAS = 3'd2;
   localparam logic [2:0] FUNC_STEP = 3'd3;
   localparam logic [2:0] FUNC_CLEAR = 3'd4;
   localparam int ACC_W = 40;
   localparam int KMAX = 2048;

   // Restoring unsigned divide; used only to fill the tanh table at start-up.
   function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned q, r;
      begin
         q = '0;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
               r = r - den;
               q[b] = 1'b1;
            end
         end
         udiv_u64 = q;
      end
   endfunction
endpackage

FILE: rtl/core/rcs_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
interface rcs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [5:0] row;
   logic [7:0] col;
   logic signed [15:0] weight;
   logic [7:0] symbol;
   modport source (output valid, func, row, col, weight, symbol, input ready);
   modport sink (input valid, func, row, col, weight, symbol, output ready);
endinterface

interface rcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] unit;
   logic signed [15:0] activation;
   logic       last;
   modport source (output valid, unit, activation, last, input ready);
   modport sink (input valid, unit, activation, last, output ready);
endinterface

FILE: rtl/core/rcs_cell.sv
// One cell of the hidden-state chain: holds one activation and passes it on.
// Depends on nothing.
module rcs_cell (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        shift,
   input  logic        load,
   input  logic [15:0] load_value,
   input  logic [15:0] shift_in,
   output logic [15:0] value
);
   logic [15:0] value_ff;
   always_ff @(posedge clock) begin
      if (reset || clear) value_ff <= '0;
      else if (load) value_ff <= load_value;
      else if (shift) value_ff <= shift_in;
   end
   assign value = value_ff;
endmodule

FILE: rtl/core/recurrent_cell_step.sv
// Recurrent cell step top level: a chain of HIDDEN cells holds the state.
// Depends on rcs_pkg, rcs_if and rcs_cell.
// Step: shared multiply-accumulate over the rotating chain and tanh lookup for each unit in
// turn, then the first result is raised and HIDDEN results follow one per cycle while not
// stalled; the next request is taken only once the last result has been taken.
// Synchronous reset clears the hidden state, not the stores.
module recurrent_cell_step #(
   parameter int HIDDEN = rcs_pkg::HIDDEN_DEF,
   parameter int SYMBOLS = rcs_pkg::SYMBOLS_DEF
) (
   input logic clock,
   input logic reset,
   rcs_req_if.sink req,
   rcs_rsp_if.source rsp
);
   import rcs_pkg::*;
   localparam int HW = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
   localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int CW = $clog2(HIDDEN + 4);
   localparam int WIW = (HIDDEN * SYMBOLS > 1) ? $clog2(HIDDEN * SYMBOLS) : 1;
   localparam int RIW = (HIDDEN > 1) ? $clog2(HIDDEN * HIDDEN) : 1;
   localparam int KW = ACC_W - 19;
   localparam int TW = $clog2(KMAX + 1);
   localparam logic [1:0] ST_IDLE = 2'd0, ST_MAC = 2'd1, ST_ACT = 2'd2, ST_OUT = 2'd3;

   logic [15:0] win_mem [HIDDEN*SYMBOLS];
   logic [15:0] wrec_mem [HIDDEN*HIDDEN];
   logic [15:0] bias_mem [HIDDEN];
   logic [15:0] nh_mem [HIDDEN];
   logic [14:0] tanh_mem [KMAX+1];

   logic [1:0] state_ff, state_in;
   logic [HW-1:0] unit_ff, unit_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] sym_ff;
   logic [15:0] win_rd_ff, wrec_rd_ff, bias_rd_ff;
   logic signed [31:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [14:0] mag_ff;
   logic neg_ff;
   logic [15:0] act_val;
   logic rsp_valid_ff;
   logic rsp_last_ff;
   logic [HW-1:0] rsp_unit_ff;

   logic [15:0] chain [HIDDEN];
   logic shift, commit, clear;
   logic acc_req;
   logic [CW-1:0] jj;

   logic signed [ACC_W-1:0] vround;
   logic signed [KW-1:0] kq, kneg;
   logic [TW-1:0] kidx;
   logic neg_k;

   // Fill the tanh ROM at start-up: entry k is round(32767*tanh(k/256)) from
   // 62-bit fixed-point exponentials.
   initial begin
      longint unsigned u, t, e, e40, num, den, n;
      logic [127:0] prod;
      u = 64'd1 << 62;
      t = 64'd1 << 62;
      e = 64'd1 << 62;
      n = 64'd1;
      while (t != 0) begin
         t = udiv_u64(t, 64'd128 * n);
         if (n[0]) u = u - t;
         else u = u + t;
         n = n + 64'd1;
      end
      for (int k = 0; k <= KMAX; k++) begin
         e40 = (e + (64'd1 << 21)) >> 22;
         num = 64'd32767 * ((64'd1 << 40) - e40);
         den = (64'd1 << 40) + e40;
         tanh_mem[k] = 15'(udiv_u64(64'd2 * num + den, 64'd2 * den));
         prod = 128'(e) * 128'(u);
         e = prod[125:62];
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign acc_req = req.valid && req.ready;
   assign clear = acc_req && req.func == FUNC_CLEAR;

   // chain turns once per product during accumulation so the head meets weight j
   assign shift = (state_ff == ST_MAC) && cnt_ff >= CW'(1) && cnt_ff < CW'(HIDDEN + 1);
   assign commit = (state_ff == ST_OUT) && rsp_valid_ff && rsp.ready && rsp_last_ff;

   for (genvar g = 0; g < HIDDEN; g++) begin : g_chain
      rcs_cell u_cell (
         .clock(clock), .reset(reset), .clear(clear), .shift(shift),
         .load(commit), .load_value(nh_mem[g]),
         .shift_in(chain[(g == HIDDEN - 1) ? 0 : g + 1]), .value(chain[g]));
   end

   // write stores
   always_ff @(posedge clock) begin
      if (acc_req && req.func == FUNC_LOAD_IN && 32'(req.row) < HIDDEN
          && 32'(req.col) < SYMBOLS)
         win_mem[WIW'(32'(req.row) * SYMBOLS + 32'(req.col))] <= req.weight;
      if (acc_req && req.func == FUNC_LOAD_REC && 32'(req.row) < HIDDEN
          && 32'(req.col) < HIDDEN)
         wrec_mem[RIW'(32'(req.row) * HIDDEN + 32'(req.col))] <= req.weight;
      if (acc_req && req.func == FUNC_LOAD_BIAS && 32'(req.row) < HIDDEN)
         bias_mem[req.row[HW-1:0]] <= req.weight;
      if (state_ff == ST_ACT) nh_mem[unit_ff] <= act_val;
   end

   // registered reads
   assign jj = cnt_ff;
   always_ff @(posedge clock) begin
      win_rd_ff <= win_mem[WIW'(32'(unit_ff) * SYMBOLS + 32'(sym_ff))];
      bias_rd_ff <= bias_mem[unit_ff];
      wrec_rd_ff <= wrec_mem[RIW'(32'(unit_ff) * HIDDEN
                                 + ((32'(jj) < HIDDEN) ? 32'(jj) : 32'd0))];
   end

   // MAC: weight j is read into wrec_rd_ff, multiplied by the chain head into prod_ff, then added to acc_ff
   always_comb begin
      vround = acc_ff + ACC_W'(1 << 18);
      kq = vround[ACC_W-1:19];
      if (kq < -KW'(KMAX)) kq = -KW'(KMAX);
      if (kq > KW'(KMAX - 1)) kq = KW'(KMAX - 1);
      neg_k = kq[KW-1];
      kneg = -kq;
      kidx = neg_k ? kneg[TW-1:0] : kq[TW-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(wrec_rd_ff) * $signed(chain[0]);
      if (state_ff == ST_MAC && cnt_ff == CW'(1))
         acc_ff <= ($signed({{(ACC_W-16){bias_rd_ff[15]}}, bias_rd_ff})
                   + $signed({{(ACC_W-16){win_rd_ff[15]}}, win_rd_ff})) <<< 15;
      else if (state_ff == ST_MAC && cnt_ff >= CW'(2) && cnt_ff < CW'(HIDDEN + 2))
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      mag_ff <= tanh_mem[kidx];
      neg_ff <= neg_k;
   end

   assign act_val = neg_ff ? -{1'b0, mag_ff} : {1'b0, mag_ff};

   // control
   always_comb begin
      state_in = state_ff;
      unit_in = unit_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc_req && req.func == FUNC_STEP && 32'(req.symbol) < SYMBOLS) begin
               state_in = ST_MAC; unit_in = '0; cnt_in = '0;
            end
         end
         ST_MAC: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(HIDDEN + 2)) state_in = ST_ACT;
         end
         ST_ACT: begin
            cnt_in = '0;
            if (32'(unit_ff) == HIDDEN - 1) begin
               state_in = ST_OUT; unit_in = '0;
            end else begin
               state_in = ST_MAC; unit_in = unit_ff + HW'(1);
            end
         end
         ST_OUT: if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // acc final at the cnt HIDDEN+1 edge; ROM read in the last MAC cycle, ACT stores it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; unit_ff <= '0; cnt_ff <= '0;
         rsp_valid_ff <= 1'b0; rsp_unit_ff <= '0; rsp_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; unit_ff <= unit_in; cnt_ff <= cnt_in;
         if (state_ff == ST_OUT) begin
            if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1; rsp_unit_ff <= '0;
               rsp_last_ff <= (HIDDEN == 1);
            end else if (rsp.ready) begin
               rsp_valid_ff <= !rsp_last_ff;
               rsp_unit_ff <= rsp_unit_ff + HW'(1);
               rsp_last_ff <= (32'(rsp_unit_ff) + 1 == HIDDEN - 1);
            end
         end
      end
      if (acc_req) sym_ff <= req.symbol[SW-1:0];
   end

   logic [15:0] rsp_act;
   assign rsp_act = nh_mem[rsp_unit_ff];
   assign rsp.valid = rsp_valid_ff;
   assign rsp.unit = 6'(rsp_unit_ff);
   assign rsp.activation = rsp_act;
   assign rsp.last = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> state_ff == ST_OUT)
      else $error("result outside output phase");
   assert property (@(posedge clock) disable iff (reset) rsp.last && rsp.valid |->
      32'(rsp_unit_ff) == HIDDEN - 1) else $error("last on wrong unit");
   assert property (@(posedge clock) disable iff (reset) shift |-> !req.ready)
      else $error("request taken during accumulate");
endmodule

FILE: bench/tb.sv
// Self-checking bench for recurrent_cell_step: drives load, step and clear requests.
// It predicts every activation with its own fixed-point tanh cell and checks each result.
// Depends on rcs_pkg, rcs_if and the recurrent_cell_step RTL.
`timescale 1ns / 1ps

module tb;
   import rcs_pkg::*;

   localparam int N_UNITS = HIDDEN_DEF;
   localparam int N_SYMS = SYMBOLS_DEF;
   localparam int TANH_TOP = 2048;
   localparam int N_RANDOM = 320;
   localparam int MAX_GAP = 13;

   typedef struct packed {
      logic [5:0] unit;
      logic signed [15:0] activation;
      logic last;
   } activation_type;

   logic clock;
   logic reset;

   rcs_req_if req_if ();
   rcs_rsp_if rsp_if ();

   recurrent_cell_step DUT (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if)
   );

   // Predictor state, kept at the block's widths.
   logic signed [15:0] win_q[N_UNITS * N_SYMS];
   logic signed [15:0] wrec_q[N_UNITS * N_UNITS];
   logic signed [15:0] bias_q[N_UNITS];
   logic signed [15:0] hidden_q[N_UNITS];
   logic [14:0] tanh_table[TANH_TOP + 1];

   // Symbols whose input-weight column is fully loaded; steps only use these.
   logic [7:0] live_syms[12] = '{8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64,
                                 8'd128, 8'd255, 8'd85, 8'd170};

   activation_type pending_acts[$];
   int errors = 0;
   int steps_sent = 0;
   int results_seen = 0;
   bit no_idle = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Build the tanh table with 62-bit fixed-point exponentials, same rounding as the block.
   task automatic build_tanh_table();
      longint unsigned u, t, e, e40, one40, num, den, n;
      bit [127:0] prod;
      u = 64'd1 << 62;
      t = 64'd1 << 62;
      e = 64'd1 << 62;
      one40 = 64'd1 << 40;
      for (n = 1; t != 0; n++) begin
         t = t / (128 * n);
         if (n[0]) u -= t;
         else u += t;
      end
      for (int k = 0; k <= TANH_TOP; k++) begin
         e40 = (e + (64'd1 << 21)) >> 22;
         num = 32767 * (one40 - e40);
         den = one40 + e40;
         tanh_table[k] = 15'((2 * num + den) / (2 * den));
         prod = 128'(e) * 128'(u);
         e = 64'(prod >> 62);
      end
   endtask

   function automatic logic signed [15:0] tanh_of_sum(longint sum);
      longint k;
      k = (sum + (64'sd1 << 18)) >>> 19;
      if (k < -TANH_TOP) k = -TANH_TOP;
      if (k > TANH_TOP - 1) k = TANH_TOP - 1;
      if (k >= 0) return 16'(tanh_table[k]);
      return -16'(tanh_table[-k]);
   endfunction

   // Apply one accepted request to the predictor; queue results for a step.
   task automatic apply_request(logic [2:0] func, logic [5:0] row, logic [7:0] col,
                                logic signed [15:0] weight, logic [7:0] symbol);
      logic signed [15:0] next_h[N_UNITS];
      longint z;
      case (func)
         FUNC_LOAD_IN: begin
            if (row < N_UNITS && col < N_SYMS) win_q[row * N_SYMS + col] = weight;
         end
         FUNC_LOAD_REC: begin
            if (row < N_UNITS && col < N_UNITS) wrec_q[row * N_UNITS + col] = weight;
         end
         FUNC_LOAD_BIAS: begin
            if (row < N_UNITS) bias_q[row] = weight;
         end
         FUNC_CLEAR: begin
            foreach (hidden_q[i]) hidden_q[i] = '0;
         end
         FUNC_STEP: begin
            if (symbol < N_SYMS) begin
               steps_sent++;
               // All units see the old hidden state; commit afterwards.
               for (int i = 0; i < N_UNITS; i++) begin
                  z = (longint'(bias_q[i]) + longint'(win_q[i * N_SYMS + symbol])) <<< 15;
                  for (int j = 0; j < N_UNITS; j++)
                     z += longint'(wrec_q[i * N_UNITS + j]) * longint'(hidden_q[j]);
                  next_h[i] = tanh_of_sum(z);
                  pending_acts.push_back('{unit: 6'(i), activation: next_h[i],
                                           last: (i == N_UNITS - 1)});
               end
               foreach (hidden_q[i]) hidden_q[i] = next_h[i];
            end
         end
         default: ;
      endcase
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(MAX_GAP);
   endfunction

   // Send one request; called and returns just after a falling edge.
   task automatic send_request(logic [2:0] func, logic [5:0] row = 0, logic [7:0] col = 0,
                               logic signed [15:0] weight = 0, logic [7:0] symbol = 0);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.func = func;
      req_if.row = row;
      req_if.col = col;
      req_if.weight = weight;
      req_if.symbol = symbol;
      req_if.valid = 1'b1;
      // Hold until the request is taken at a rising edge.
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      apply_request(func, row, col, weight, symbol);
      @(negedge clock);
   endtask

   // Mostly modest weights so activations stay off the rails; sometimes full range.
   function automatic logic signed [15:0] draw_weight();
      if ($urandom_range(7) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(2047)) - 1024);
   endfunction

   // Result side: random stall before each result, then compare with the oldest prediction.
   initial begin
      activation_type want;
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = draw_gap();
         rsp_if.ready = 1'b0;
         repeat (stall) @(negedge clock);
         rsp_if.ready = 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_if.valid && !reset) break;
         end
         results_seen++;
         if (pending_acts.size() == 0) begin
            $error("unexpected result: unit %0d activation %0d", rsp_if.unit,
                   rsp_if.activation);
            errors++;
         end else begin
            want = pending_acts.pop_front();
            if (rsp_if.unit !== want.unit) begin
               $error("unit: expected %0d, got %0d", want.unit, rsp_if.unit);
               errors++;
            end
            if (rsp_if.activation !== want.activation) begin
               $error("activation: expected %0d, got %0d", want.activation,
                      rsp_if.activation);
               errors++;
            end
            if (rsp_if.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_if.last);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   // Fill every recurrent weight, every bias and the input columns that steps will use.
   task automatic test_fill_stores();
      no_idle = 1;
      for (int i = 0; i < N_UNITS; i++) begin
         send_request(FUNC_LOAD_BIAS, 6'(i), 0, draw_weight());
         foreach (live_syms[s]) send_request(FUNC_LOAD_IN, 6'(i), live_syms[s], draw_weight());
         for (int j = 0; j < N_UNITS; j++)
            send_request(FUNC_LOAD_REC, 6'(i), 8'(j), draw_weight());
      end
      no_idle = 0;
   endtask

   // Extremes, ignored requests, clear, and saturation at both ends of the tanh range.
   task automatic test_directed();
      send_request(FUNC_STEP, 0, 0, 0, 8'd0);
      send_request(FUNC_STEP, 0, 0, 0, 8'd255);
      // Out-of-range loads must leave the stores alone.
      send_request(FUNC_LOAD_BIAS, 6'd63, 0, 16'sh7fff);
      send_request(FUNC_LOAD_REC, 6'd0, 8'd255, 16'sh7fff);
      send_request(FUNC_LOAD_REC, 6'd40, 8'd3, -16'sd32768);
      send_request(FUNC_LOAD_IN, 6'd32, 8'd0, 16'sh7fff);
      // Unused function codes give nothing.
      for (int f = FUNC_CLEAR + 1; f < 8; f++) send_request(3'(f), 6'd1, 8'd1, 16'sh7fff, 8'd1);
      send_request(FUNC_STEP, 0, 0, 0, 8'd85);
      send_request(FUNC_CLEAR);
      send_request(FUNC_STEP, 0, 0, 0, 8'd170);
      // Push unit 0 hard positive and unit 1 hard negative.
      send_request(FUNC_LOAD_BIAS, 6'd0, 0, 16'sh7fff);
      send_request(FUNC_LOAD_IN, 6'd0, 8'd1, 16'sh7fff);
      send_request(FUNC_LOAD_BIAS, 6'd1, 0, -16'sd32768);
      send_request(FUNC_LOAD_IN, 6'd1, 8'd1, -16'sd32768);
      send_request(FUNC_LOAD_REC, 6'd31, 8'd31, -16'sd32768);
      send_request(FUNC_STEP, 0, 0, 0, 8'd1);
      send_request(FUNC_STEP, 0, 0, 0, 8'd1);
      send_request(FUNC_CLEAR);
   endtask

   task automatic test_random_mix();
      int pick;
      for (int n = 0; n < N_RANDOM; n++) begin
         // Run some stretches back to back.
         if (n % 64 == 0) no_idle = ($urandom_range(2) == 0);
         pick = $urandom_range(99);
         if (pick < 35)
            send_request(FUNC_STEP, 6'($urandom), 8'($urandom), 16'($urandom),
                         live_syms[$urandom_range(11)]);
         else if (pick < 63)
            send_request(FUNC_LOAD_REC, 6'($urandom_range(31)), 8'($urandom_range(31)),
                         draw_weight());
         else if (pick < 78)
            send_request(FUNC_LOAD_IN, 6'($urandom_range(31)), live_syms[$urandom_range(11)],
                         draw_weight());
         else if (pick < 86)
            send_request(FUNC_LOAD_BIAS, 6'($urandom_range(31)), 8'($urandom), draw_weight());
         else if (pick < 90)
            send_request(FUNC_CLEAR, 6'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
         else if (pick < 96)
            // Row or source unit beyond the cell size: dropped.
            send_request($urandom_range(1) ? FUNC_LOAD_REC : FUNC_LOAD_BIAS,
                         6'($urandom_range(63, 32)), 8'($urandom), 16'($urandom));
         else
            send_request(3'($urandom_range(7, FUNC_CLEAR + 1)), 6'($urandom), 8'($urandom),
                         16'($urandom), 8'($urandom));
      end
      no_idle = 0;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.func = FUNC_CLEAR;
      req_if.row = '0;
      req_if.col = '0;
      req_if.weight = '0;
      req_if.symbol = '0;
      reset = 1'b1;
      build_tanh_table();
      foreach (hidden_q[i]) hidden_q[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_stores();
      test_directed();
      test_random_mix();
      req_if.valid = 1'b0;

      // Drain outstanding activations, then give the block a little more time.
      wait (pending_acts.size() == 0);
      repeat (40) @(posedge clock);

      $display("Covered %0d steps and %0d results over loads, clears and dropped requests.",
               steps_sent, results_seen);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d activations outstanding.", pending_acts.size());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
